// ----- hdl/qrm_pkg.sv -----
// Shared types and constants for the ordered queue with remove by value.
// No dependencies; compiled first.
package qrm_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int unsigned DepthDefault      = 16;
  localparam int unsigned ValueWidthDefault = 16;

  // Request codes as carried on the request channel
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_COUNT  = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  // Per-cell control from the controller
  typedef struct packed {
    logic write;  // load the appended value
    logic shift;  // take the right neighbor's entry
    logic wrap;   // with shift: take the head entry instead (rotation)
  } cell_ctl_t;

endpackage

// ----- hdl/qrm_if.sv -----
// Valid/ready channel interfaces for the request and result items.
// Depends on nothing; port widths follow the parameters.
interface qrm_req_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [VALUE_WIDTH-1:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface qrm_rsp_if #(
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned CNT_WIDTH   = 5
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [CNT_WIDTH-1:0]   match_count;
  logic [CNT_WIDTH-1:0]   fill_level;
  logic                   is_empty;

  modport source (output valid, output status, output out_value, output match_count,
                  output fill_level, output is_empty, input ready);
  modport sink   (input valid, input status, input out_value, input match_count,
                  input fill_level, input is_empty, output ready);
endinterface

// ----- hdl/qrm_cell.sv -----
// One storage cell of the queue chain: holds one entry and hands it left.
// Depends on qrm_pkg (cell_ctl_t).
module qrm_cell #(
  parameter int unsigned VALUE_WIDTH = qrm_pkg::ValueWidthDefault
) (
  input  logic                   clk_i,
  input  qrm_pkg::cell_ctl_t     ctl_i,
  input  logic [VALUE_WIDTH-1:0] wr_data_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic [VALUE_WIDTH-1:0] head_i,
  output logic [VALUE_WIDTH-1:0] data_o
);

  logic [VALUE_WIDTH-1:0] data_q, data_d;

  // Append write wins; otherwise shift left, or wrap the head into the tail
  always_comb begin
    data_d = data_q;
    if (ctl_i.write) begin
      data_d = wr_data_i;
    end else if (ctl_i.shift) begin
      data_d = ctl_i.wrap ? head_i : right_i;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hdl/fifo_queue_with_remove_by_value.sv -----
// Ordered queue of identifiers with pop, remove-first-match and count.
// Depends on qrm_pkg, qrm_if (qrm_req_if, qrm_rsp_if) and qrm_cell.
//
// The queue is a row of DEPTH cells with the head in cell 0. One request is
// handled at a time and gives exactly one result item, held in an output
// register. A new request is taken only when that register is empty or its
// item leaves in the same cycle. Append and pop write or shift the cell row
// once and load their result in the cycle they are accepted. Remove and count
// rotate the valid entries through the head comparator, one entry per cycle,
// and load their result once every entry held at acceptance has passed the
// head. The rotation restores the original order, and a removed entry is
// simply not rotated back in. Entry contents are not reset; only the fill
// count, the controller state and the result valid flag are.
module fifo_queue_with_remove_by_value #(
  parameter int unsigned DEPTH       = qrm_pkg::DepthDefault,
  parameter int unsigned VALUE_WIDTH = qrm_pkg::ValueWidthDefault,
  parameter int unsigned CNT_WIDTH   = $clog2(DEPTH + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qrm_req_if.sink   req_i,
  qrm_rsp_if.source rsp_o
);

  localparam logic [CNT_WIDTH-1:0] CntFull = CNT_WIDTH'(DEPTH);
  localparam logic [CNT_WIDTH-1:0] CntOne  = CNT_WIDTH'(1);

  // Control state
  qrm_pkg::state_e        state_q, state_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                   rsp_valid_q, rsp_valid_d;

  // Scan context
  qrm_pkg::req_e          op_q, op_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CNT_WIDTH-1:0]   step_q, step_d;
  logic [CNT_WIDTH-1:0]   orig_q, orig_d;
  logic                   found_q, found_d;
  logic [CNT_WIDTH-1:0]   matches_q, matches_d;
  logic [VALUE_WIDTH-1:0] outv_q, outv_d;

  // Result register
  qrm_pkg::status_e       status_q, status_d;
  logic [VALUE_WIDTH-1:0] rsp_value_q, rsp_value_d;
  logic [CNT_WIDTH-1:0]   rsp_match_q, rsp_match_d;
  logic [CNT_WIDTH-1:0]   rsp_fill_q, rsp_fill_d;
  logic                   rsp_load;

  // Cell row control
  logic                   shift_en, wrap_en, write_en;
  logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
  logic [VALUE_WIDTH-1:0] head;
  logic                   head_match;
  logic                   drop;
  qrm_pkg::req_e          req_op;

  assign head       = cell_data[0];
  assign req_op     = qrm_pkg::req_e'(req_i.req_type);
  assign head_match = (head == val_q);
  assign drop       = (op_q == qrm_pkg::REQ_REMOVE) && !found_q && head_match;

  // Next state, scan bookkeeping and result capture
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    val_d       = val_q;
    step_d      = step_q;
    orig_d      = orig_q;
    found_d     = found_q;
    matches_d   = matches_q;
    outv_d      = outv_q;
    status_d    = qrm_pkg::ST_OK;
    rsp_value_d = '0;
    rsp_match_d = '0;
    rsp_load    = 1'b0;
    shift_en    = 1'b0;
    wrap_en     = 1'b0;
    write_en    = 1'b0;
    req_i.ready = 1'b0;

    case (state_q)
      qrm_pkg::S_IDLE: begin
        req_i.ready = !rsp_valid_q || rsp_o.ready;
        if (req_i.ready && req_i.valid) begin
          case (req_op)
            qrm_pkg::REQ_APPEND: begin
              rsp_load = 1'b1;
              if (cnt_q == CntFull) begin
                status_d = qrm_pkg::ST_FULL;
              end else begin
                write_en = 1'b1;
                cnt_d    = cnt_q + CntOne;
              end
            end
            qrm_pkg::REQ_POP: begin
              rsp_load = 1'b1;
              if (cnt_q == '0) begin
                status_d = qrm_pkg::ST_MISS;
              end else begin
                rsp_value_d = head;
                shift_en    = 1'b1;
                cnt_d       = cnt_q - CntOne;
              end
            end
            default: begin
              // remove or count: rotate every valid entry past the head
              state_d   = qrm_pkg::S_SCAN;
              op_d      = req_op;
              val_d     = req_i.item_value;
              step_d    = '0;
              orig_d    = cnt_q;
              found_d   = 1'b0;
              matches_d = '0;
              outv_d    = '0;
            end
          endcase
        end
      end
      qrm_pkg::S_SCAN: begin
        if (step_q == orig_q) begin
          // every original entry has passed the head
          rsp_load = 1'b1;
          state_d  = qrm_pkg::S_IDLE;
          if (op_q == qrm_pkg::REQ_REMOVE) begin
            status_d    = found_q ? qrm_pkg::ST_OK : qrm_pkg::ST_MISS;
            rsp_value_d = outv_q;
          end else begin
            rsp_match_d = matches_q;
          end
        end else begin
          shift_en = 1'b1;
          step_d   = step_q + CntOne;
          if (drop) begin
            found_d = 1'b1;
            outv_d  = head;
            cnt_d   = cnt_q - CntOne;
          end else begin
            wrap_en = 1'b1;
          end
          if (op_q == qrm_pkg::REQ_COUNT && head_match) begin
            matches_d = matches_q + CntOne;
          end
        end
      end
      default: begin
        state_d = qrm_pkg::S_IDLE;
      end
    endcase

    rsp_fill_d  = cnt_d;
    rsp_valid_d = rsp_load || (rsp_valid_q && !rsp_o.ready);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qrm_pkg::S_IDLE;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Scan context and result payload
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    step_q    <= step_d;
    orig_q    <= orig_d;
    found_q   <= found_d;
    matches_q <= matches_d;
    outv_q    <= outv_d;
    if (rsp_load) begin
      status_q    <= status_d;
      rsp_value_q <= rsp_value_d;
      rsp_match_q <= rsp_match_d;
      rsp_fill_q  <= rsp_fill_d;
    end
  end

  // Cell row: tail cell during a rotation takes the head entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    qrm_pkg::cell_ctl_t     ctl;
    logic [VALUE_WIDTH-1:0] right;

    assign ctl.write = write_en && (CNT_WIDTH'(i) == cnt_q);
    assign ctl.shift = shift_en;
    assign ctl.wrap  = wrap_en && (CNT_WIDTH'(i) == cnt_q - CntOne);

    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    qrm_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .wr_data_i (req_i.item_value),
      .right_i   (right),
      .head_i    (head),
      .data_o    (cell_data[i])
    );
  end

  // Result channel
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_value   = rsp_value_q;
  assign rsp_o.match_count = rsp_match_q;
  assign rsp_o.fill_level  = rsp_fill_q;
  assign rsp_o.is_empty    = (rsp_fill_q == '0);

endmodule
